### rtl/html_text_escaper_defines.svh
// ----------------------------------------------------------------------------
// HTML text escaper assertion macros
// Shared concurrent assertion forms used by the escaper RTL.
// ----------------------------------------------------------------------------
`ifndef HTML_TEXT_ESCAPER_DEFINES_SVH
`define HTML_TEXT_ESCAPER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error("html_text_escaper assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error("html_text_escaper assertion failed");

`endif

### rtl/hte_pkg.sv
// ----------------------------------------------------------------------------
// HTML text escaper package
// Beat types, escape tokens and the token text tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hte_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int TOK_IDX_W   = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       msg_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       msg_end;
    } t_out_beat;

    typedef enum logic [2:0] {
        TOK_PLAIN,
        TOK_BR,
        TOK_LT,
        TOK_GT,
        TOK_AMP,
        TOK_QUOT,
        TOK_NBSP
    } t_tok;

    typedef struct packed {
        logic       has_a;
        t_tok       tok_a;
        logic [7:0] byte_a;
        logic       has_b;
        t_tok       tok_b;
        logic [7:0] byte_b;
        logic       msg_last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic is_alnum(input logic [7:0] c);
        return ((c >= "0") && (c <= "9")) || ((c >= "A") && (c <= "Z")) ||
               ((c >= "a") && (c <= "z"));
    endfunction

    function automatic t_tok classify(input logic [7:0] c, input logic wrap,
                                      input logic prev_an, input logic next_an);
        t_tok tok;
        tok = TOK_PLAIN;
        if (c == "\n") begin
            tok = wrap ? TOK_BR : TOK_PLAIN;
        end else if (c == "<") begin
            tok = TOK_LT;
        end else if (c == ">") begin
            tok = TOK_GT;
        end else if (c == "&") begin
            tok = TOK_AMP;
        end else if (c == "\"") begin
            tok = TOK_QUOT;
        end else if ((c == " ") && wrap && !(prev_an && next_an)) begin
            tok = TOK_NBSP;
        end
        return tok;
    endfunction

    function automatic logic [TOK_IDX_W-1:0] tok_len(input t_tok tok);
        logic [TOK_IDX_W-1:0] len;
        case (tok)
            TOK_PLAIN: len = 3'd1;
            TOK_BR:    len = 3'd5;
            TOK_LT:    len = 3'd4;
            TOK_GT:    len = 3'd4;
            TOK_AMP:   len = 3'd5;
            TOK_QUOT:  len = 3'd6;
            TOK_NBSP:  len = 3'd6;
            default:   len = 3'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] tok_char(input t_tok tok,
                                            input logic [TOK_IDX_W-1:0] idx,
                                            input logic [7:0] raw);
        logic [7:0] ch;
        ch = raw;
        case (tok)
            TOK_BR: begin
                case (idx)
                    3'd0:    ch = "\n";
                    3'd1:    ch = "<";
                    3'd2:    ch = "B";
                    3'd3:    ch = "R";
                    default: ch = ">";
                endcase
            end
            TOK_LT: begin
                case (idx)
                    3'd0:    ch = "&";
                    3'd1:    ch = "l";
                    3'd2:    ch = "t";
                    default: ch = ";";
                endcase
            end
            TOK_GT: begin
                case (idx)
                    3'd0:    ch = "&";
                    3'd1:    ch = "g";
                    3'd2:    ch = "t";
                    default: ch = ";";
                endcase
            end
            TOK_AMP: begin
                case (idx)
                    3'd0:    ch = "&";
                    3'd1:    ch = "a";
                    3'd2:    ch = "m";
                    3'd3:    ch = "p";
                    default: ch = ";";
                endcase
            end
            TOK_QUOT: begin
                case (idx)
                    3'd0:    ch = "&";
                    3'd1:    ch = "q";
                    3'd2:    ch = "u";
                    3'd3:    ch = "o";
                    3'd4:    ch = "t";
                    default: ch = ";";
                endcase
            end
            TOK_NBSP: begin
                case (idx)
                    3'd0:    ch = "&";
                    3'd1:    ch = "n";
                    3'd2:    ch = "b";
                    3'd3:    ch = "s";
                    3'd4:    ch = "p";
                    default: ch = ";";
                endcase
            end
            default: ch = raw;
        endcase
        return ch;
    endfunction

endpackage

### rtl/hte_front.sv
// ----------------------------------------------------------------------------
// HTML text escaper front end
// Accepts input beats, holds one byte for lookahead and classifies bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hte_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  hte_pkg::t_in_beat i_data,
    output logic              o_stall,
    input  logic              i_wrap,
    input  logic              i_q_full,
    output logic              o_push,
    output hte_pkg::t_job     o_job
);

    logic [7:0] r_held;
    logic [7:0] n_held;
    logic       r_held_vld;
    logic       n_held_vld;
    logic       r_prev_an;
    logic       n_prev_an;
    logic       accept;
    logic       new_prev_an;

    assign o_stall     = i_q_full;
    assign accept      = i_valid && !i_q_full;
    assign new_prev_an = r_held_vld ? hte_pkg::is_alnum(r_held) : r_prev_an;

    always_comb begin
        o_job.has_a    = r_held_vld;
        o_job.tok_a    = hte_pkg::classify(r_held, i_wrap, r_prev_an,
                                           hte_pkg::is_alnum(i_data.in_byte));
        o_job.byte_a   = r_held;
        o_job.has_b    = i_data.msg_last;
        o_job.tok_b    = hte_pkg::classify(i_data.in_byte, i_wrap, new_prev_an,
                                           1'b0);
        o_job.byte_b   = i_data.in_byte;
        o_job.msg_last = i_data.msg_last;
        o_push         = accept && (r_held_vld || i_data.msg_last);
    end

    always_comb begin
        n_held     = r_held;
        n_held_vld = r_held_vld;
        n_prev_an  = r_prev_an;
        if (accept) begin
            if (i_data.msg_last) begin
                n_held_vld = 1'b0;
                n_prev_an  = 1'b0;
            end else begin
                n_held     = i_data.in_byte;
                n_held_vld = 1'b1;
                n_prev_an  = new_prev_an;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        if (!i_rst_n) begin
            r_held_vld <= 1'b0;
            r_prev_an  <= 1'b0;
        end else begin
            r_held_vld <= n_held_vld;
            r_prev_an  <= n_prev_an;
        end
    end

endmodule

### rtl/hte_queue.sv
// ----------------------------------------------------------------------------
// HTML text escaper job queue
// Short FIFO of classified jobs between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hte_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  hte_pkg::t_job      i_job,
    input  logic               i_pop,
    output hte_pkg::t_job      o_head,
    output hte_pkg::t_q_status o_status
);

    hte_pkg::t_job                  r_mem [hte_pkg::QUEUE_DEPTH];
    logic [hte_pkg::QUEUE_AW-1:0]   r_wr_ptr;
    logic [hte_pkg::QUEUE_AW-1:0]   n_wr_ptr;
    logic [hte_pkg::QUEUE_AW-1:0]   r_rd_ptr;
    logic [hte_pkg::QUEUE_AW-1:0]   n_rd_ptr;
    logic [hte_pkg::QUEUE_CW-1:0]   r_count;
    logic [hte_pkg::QUEUE_CW-1:0]   n_count;
    logic                           do_wr;
    logic                           do_rd;

    always_comb begin
        o_status.full  = (r_count == hte_pkg::QUEUE_CW'(hte_pkg::QUEUE_DEPTH));
        o_status.empty = (r_count == '0);
        o_head         = r_mem[r_rd_ptr];
        do_wr          = i_push && !o_status.full;
        do_rd          = i_pop && !o_status.empty;
        n_wr_ptr       = do_wr ? r_wr_ptr + hte_pkg::QUEUE_AW'(1) : r_wr_ptr;
        n_rd_ptr       = do_rd ? r_rd_ptr + hte_pkg::QUEUE_AW'(1) : r_rd_ptr;
        n_count        = r_count;
        if (do_wr && !do_rd) begin
            n_count = r_count + hte_pkg::QUEUE_CW'(1);
        end else if (do_rd && !do_wr) begin
            n_count = r_count - hte_pkg::QUEUE_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### rtl/hte_back.sv
// ----------------------------------------------------------------------------
// HTML text escaper back end
// Expands queued jobs into output bytes, one byte per cycle while a job is queued and the output is not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hte_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hte_pkg::t_job      i_head,
    input  hte_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_valid,
    output hte_pkg::t_out_beat o_data,
    input  logic               i_stall
);

    logic                          r_sel;
    logic                          n_sel;
    logic [hte_pkg::TOK_IDX_W-1:0] r_idx;
    logic [hte_pkg::TOK_IDX_W-1:0] n_idx;
    logic                          r_vld;
    logic                          n_vld;
    hte_pkg::t_out_beat            r_out;
    hte_pkg::t_out_beat            n_out;
    logic                          eff_sel;
    hte_pkg::t_tok                 tok;
    logic [7:0]                    raw;
    logic                          tok_end;
    logic                          ent_end;
    logic                          advance;

    assign o_valid = r_vld;
    assign o_data  = r_out;

    always_comb begin
        eff_sel = r_sel || !i_head.has_a;
        tok     = eff_sel ? i_head.tok_b : i_head.tok_a;
        raw     = eff_sel ? i_head.byte_b : i_head.byte_a;
        tok_end = (r_idx == hte_pkg::tok_len(tok) - hte_pkg::TOK_IDX_W'(1));
        ent_end = tok_end && (eff_sel || !i_head.has_b);
        advance = !i_q_status.empty && (!r_vld || !i_stall);
        o_pop   = advance && ent_end;

        n_sel = r_sel;
        n_idx = r_idx;
        n_vld = r_vld && i_stall;
        n_out = r_out;
        if (advance) begin
            n_vld          = 1'b1;
            n_out.out_byte = hte_pkg::tok_char(tok, r_idx, raw);
            n_out.run_last = ent_end;
            n_out.msg_end  = ent_end && i_head.msg_last;
            if (tok_end) begin
                n_idx = '0;
                n_sel = !ent_end;
            end else begin
                n_idx = r_idx + hte_pkg::TOK_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_sel <= 1'b0;
            r_idx <= '0;
            r_vld <= 1'b0;
        end else begin
            r_sel <= n_sel;
            r_idx <= n_idx;
            r_vld <= n_vld;
        end
    end

endmodule

### rtl/html_text_escaper.sv
// ----------------------------------------------------------------------------
// HTML text escaper
// HTML-escapes a byte stream, with optional line break and space handling.
// ----------------------------------------------------------------------------
// The block takes one input beat per cycle while o_stall is low and gives one
// output byte per cycle while i_stall is low and a job is queued. Each byte
// is held back until the next beat arrives, so a byte appears only after its
// successor or after the message's last beat. A plain byte gives one output
// byte, an escaped byte four to six (&lt; &gt; &amp; &quot; &nbsp; and the
// newline with <BR>). The output side sets the sustained rate; a four-entry job
// queue between front and back end absorbs expansions before input stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "html_text_escaper_defines.svh"

module html_text_escaper (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  hte_pkg::t_in_beat  i_data,
    output logic               o_stall,
    output logic               o_valid,
    output hte_pkg::t_out_beat o_data,
    input  logic               i_stall,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);

    logic               r_wrap;
    logic               n_wrap;
    logic               push;
    logic               pop;
    hte_pkg::t_job      job;
    hte_pkg::t_job      head;
    hte_pkg::t_q_status q_status;

    assign o_cfg_ready = 1'b1;
    assign n_wrap      = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap <= 1'b0;
        end else begin
            r_wrap <= n_wrap;
        end
    end

    hte_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .o_stall  (o_stall),
        .i_wrap   (r_wrap),
        .i_q_full (q_status.full),
        .o_push   (push),
        .o_job    (job)
    );

    hte_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (job),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    hte_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall)
    );

    `HTE_ASSERT_NOW(a_msg_end_closes_run, i_clk, i_rst_n, o_valid && o_data.msg_end, o_data.run_last)
    `HTE_ASSERT_NEXT(a_run_no_gap, i_clk, i_rst_n, o_valid && !i_stall && !o_data.run_last, o_valid)
    `HTE_ASSERT_NOW(a_stall_after_beat, i_clk, i_rst_n, $rose(o_stall), $past(i_valid && !o_stall))

endmodule

### bench/html_text_escaper_test.sv
// ----------------------------------------------------------------------------
// HTML text escaper testbench
// Streams text messages through the escaper under random input gaps and
// output stalls, with wrap mode switched between phases and at least once in the
// middle of a message. A byte-level model of the escaping predicts every
// output beat, and each beat is compared field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module html_text_escaper_test;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int PHASE_BEATS    = 48;
    localparam int RANDOM_PHASES  = 6;

    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UZ   = 8'h5A;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LZ   = 8'h7A;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    hte_pkg::t_in_beat   in_beat   = '0;
    logic                in_stall;
    logic                out_valid;
    hte_pkg::t_out_beat  out_beat;
    logic                out_stall = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_wrap  = 1'b0;

    hte_pkg::t_in_beat   pending_text[$];
    hte_pkg::t_out_beat  expected_text[$];
    logic [7:0]          step_bytes[$];

    logic [7:0]          held_byte_m   = '0;
    bit                  held_valid_m  = 1'b0;
    logic [7:0]          prior_byte_m  = '0;
    bit                  wrap_m        = 1'b0;

    bit                  send_idle_en  = 1'b1;
    bit                  sink_stall_en = 1'b1;
    int                  gap_left      = 0;
    int                  stall_left    = 0;
    int                  idle_cycles   = 0;
    int                  mismatch_count = 0;

    html_text_escaper u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .i_data      (in_beat),
        .o_stall     (in_stall),
        .o_valid     (out_valid),
        .o_data      (out_beat),
        .i_stall     (out_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_wrap)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic bit is_word_char(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
               (c >= CH_LA && c <= CH_LZ);
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            step_bytes.push_back(s[i]);
        end
    endtask

    task automatic expand_byte(input logic [7:0] c, input logic [7:0] prev,
                               input logic [7:0] nxt);
        if (c == CH_NL) begin
            if (wrap_m) begin
                add_text("\n<BR>");
            end else begin
                step_bytes.push_back(c);
            end
        end else if (c == CH_LT) begin
            add_text("&lt;");
        end else if (c == CH_GT) begin
            add_text("&gt;");
        end else if (c == CH_AMP) begin
            add_text("&amp;");
        end else if (c == CH_QUOT) begin
            add_text("&quot;");
        end else if (c == CH_SP && wrap_m && !(is_word_char(prev) && is_word_char(nxt))) begin
            add_text("&nbsp;");
        end else begin
            step_bytes.push_back(c);
        end
    endtask

    // The held byte is expanded once its successor is known; a last byte is
    // expanded at once with a non-alphanumeric successor.
    task automatic escape_step(input hte_pkg::t_in_beat beat);
        logic [7:0]         prev_for_new;
        hte_pkg::t_out_beat r;
        prev_for_new = prior_byte_m;
        step_bytes.delete();
        if (held_valid_m) begin
            expand_byte(held_byte_m, prior_byte_m, beat.in_byte);
            prev_for_new = held_byte_m;
        end
        if (beat.msg_last) begin
            expand_byte(beat.in_byte, prev_for_new, 8'h00);
            held_byte_m  = '0;
            held_valid_m = 1'b0;
            prior_byte_m = '0;
        end else begin
            prior_byte_m = prev_for_new;
            held_byte_m  = beat.in_byte;
            held_valid_m = 1'b1;
        end
        foreach (step_bytes[i]) begin
            r.out_byte = step_bytes[i];
            r.run_last = (i == step_bytes.size() - 1);
            r.msg_end  = r.run_last && beat.msg_last;
            expected_text.push_back(r);
        end
    endtask

    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 96) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [7:0] random_text_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            case ($urandom_range(0, 2))
                0:       return CH_0 + 8'($urandom_range(0, 9));
                1:       return CH_UA + 8'($urandom_range(0, 25));
                default: return CH_LA + 8'($urandom_range(0, 25));
            endcase
        end else if (r < 55) begin
            return CH_SP;
        end else if (r < 70) begin
            case ($urandom_range(0, 4))
                0:       return CH_LT;
                1:       return CH_GT;
                2:       return CH_AMP;
                3:       return CH_QUOT;
                default: return CH_NL;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Driver: offers the next pending byte once the current beat is taken.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_beat  <= '0;
        end else begin
            if (in_valid && !in_stall) begin
                escape_step(in_beat);
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_text.size() != 0) begin
                    in_valid <= 1'b1;
                    in_beat  <= pending_text.pop_front();
                    gap_left = send_idle_en ? idle_len() : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each output beat and drives the output stall.
    always @(posedge clk) begin : monitor
        hte_pkg::t_out_beat want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_text.size() == 0) begin
                    report_mismatch("beat with nothing expected, out_byte",
                                    out_beat.out_byte, 8'h00);
                end else begin
                    want = expected_text.pop_front();
                    if (out_beat.out_byte !== want.out_byte) begin
                        report_mismatch("out_byte", out_beat.out_byte, want.out_byte);
                    end
                    if (out_beat.run_last !== want.run_last) begin
                        report_mismatch("run_last", 8'(out_beat.run_last),
                                        8'(want.run_last));
                    end
                    if (out_beat.msg_end !== want.msg_end) begin
                        report_mismatch("msg_end", 8'(out_beat.msg_end),
                                        8'(want.msg_end));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (sink_stall_en && $urandom_range(0, 3) == 0) begin
                stall_left = idle_len();
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b, input bit last);
        hte_pkg::t_in_beat beat;
        beat.in_byte  = b;
        beat.msg_last = last;
        pending_text.push_back(beat);
    endtask

    task automatic queue_message(input string s, input bit ends);
        for (int i = 0; i < s.len(); i++) begin
            queue_byte(s[i], ends && (i == s.len() - 1));
        end
    endtask

    // The state is looked at on the falling edge, after every update of the
    // rising edge has settled.
    task automatic wait_idle();
        do begin
            @(negedge clk);
        end while (pending_text.size() != 0 || in_valid || expected_text.size() != 0);
    endtask

    // A held byte gives no output yet, so the block gets extra cycles to
    // settle before the register changes.
    task automatic write_wrap(input bit value);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_wrap  <= value;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        wrap_m = value;
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int left_in_msg;
        left_in_msg = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_wrap(1'b0);
        queue_message("<>&\"\n ", 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_message("A", 1'b1);

        write_wrap(1'b1);
        queue_message(" a b  Z [\n", 1'b1);
        queue_message(" ", 1'b1);
        queue_message("x ", 1'b0);
        write_wrap(1'b0);
        queue_message("y", 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0, 2, 3: write_wrap(1'b1);
                1, 4:    write_wrap(1'b0);
                default: write_wrap(1'($urandom_range(0, 1)));
            endcase
            send_idle_en  = (p != 2) && (p != 4);
            sink_stall_en = (p != 2) && (p != 5);
            for (int k = 0; k < PHASE_BEATS; k++) begin
                if (left_in_msg == 0) begin
                    left_in_msg = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20)
                                                              : $urandom_range(1, 8);
                end
                queue_byte(random_text_byte(), left_in_msg == 1);
                left_in_msg--;
                if (left_in_msg == 0 && $urandom_range(0, 9) == 0) begin
                    wait_idle();
                end
            end
        end
        if (left_in_msg != 0) begin
            queue_byte(random_text_byte(), 1'b1);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/hte_pkg.sv
rtl/hte_front.sv
rtl/hte_queue.sv
rtl/hte_back.sv
rtl/html_text_escaper.sv
bench/html_text_escaper_test.sv
